@@ rtl/core/swxy_pkg.sv @@
// Shared constants for the sliding-window x/y range tracker.
`default_nettype none

package swxy_pkg;

    localparam int WINDOW_DEPTH_DEFAULT = 128;
    localparam int SAMPLE_WIDTH_DEFAULT = 32;

    localparam int CFG_WIDTH = 8;
    localparam logic [CFG_WIDTH-1:0] WINDOW_SIZE_RESET = 8'd100;

    localparam logic FUNC_ADD   = 1'b0;
    localparam logic FUNC_CLEAR = 1'b1;

endpackage

`default_nettype wire

@@ rtl/core/swxy_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module swxy_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ rtl/core/swxy_bound_unit.sv @@
// Shared min/max compare unit: folds one point into the four bounds, or seeds all four with it.
`default_nettype none

module swxy_bound_unit #(
    parameter int SAMPLE_WIDTH = 32
) (
    input  wire logic                           seed,
    input  wire logic signed [SAMPLE_WIDTH-1:0] pt_x,
    input  wire logic signed [SAMPLE_WIDTH-1:0] pt_y,
    input  wire logic signed [SAMPLE_WIDTH-1:0] cur_min_x,
    input  wire logic signed [SAMPLE_WIDTH-1:0] cur_max_x,
    input  wire logic signed [SAMPLE_WIDTH-1:0] cur_min_y,
    input  wire logic signed [SAMPLE_WIDTH-1:0] cur_max_y,
    output logic      signed [SAMPLE_WIDTH-1:0] nxt_min_x,
    output logic      signed [SAMPLE_WIDTH-1:0] nxt_max_x,
    output logic      signed [SAMPLE_WIDTH-1:0] nxt_min_y,
    output logic      signed [SAMPLE_WIDTH-1:0] nxt_max_y
);

    // equal values leave a bound alone
    always_comb
    begin
        nxt_min_x = (seed || (pt_x < cur_min_x)) ? pt_x : cur_min_x;
        nxt_max_x = (seed || (pt_x > cur_max_x)) ? pt_x : cur_max_x;
        nxt_min_y = (seed || (pt_y < cur_min_y)) ? pt_y : cur_min_y;
        nxt_max_y = (seed || (pt_y > cur_max_y)) ? pt_y : cur_max_y;
    end

endmodule

`default_nettype wire

@@ rtl/core/sliding_window_xy_range_tracker.sv @@
// Top level: ring store, scan sequencer and output register of the range tracker.
`default_nettype none

// Keeps the last window_size (x,y) points in a ring RAM and reports min/max of
// x and y plus the point count, one result word per input word. A clear, or an
// add while the window is still filling, goes from IDLE to FINISH and from there
// into the output register once it is free. An add into a full window passes
// through SCAN first: the bounds are rebuilt by reading stored_count entries of
// the RAM one entry per cycle through its single read port and one shared
// compare unit. The block takes no new word while a word is in work; a finished
// result sits in the output register and does not hold off the next word.
// window_size is sampled into the active window only at reset and on a clear;
// values of 0 act as 1 and values above the depth act as the depth.
module sliding_window_xy_range_tracker #(
    parameter int WINDOW_DEPTH = swxy_pkg::WINDOW_DEPTH_DEFAULT,
    parameter int SAMPLE_WIDTH = swxy_pkg::SAMPLE_WIDTH_DEFAULT
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [swxy_pkg::CFG_WIDTH-1:0]      cfg_data,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic                                func,
    input  wire logic signed [SAMPLE_WIDTH-1:0]      x_value,
    input  wire logic signed [SAMPLE_WIDTH-1:0]      y_value,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic      signed [SAMPLE_WIDTH-1:0]      min_x,
    output logic      signed [SAMPLE_WIDTH-1:0]      max_x,
    output logic      signed [SAMPLE_WIDTH-1:0]      min_y,
    output logic      signed [SAMPLE_WIDTH-1:0]      max_y,
    output logic      [$clog2(WINDOW_DEPTH+1)-1:0]   point_count
);

    localparam int AW   = $clog2(WINDOW_DEPTH);
    localparam int CW   = $clog2(WINDOW_DEPTH + 1);
    localparam int SUMW = CW + 1;
    localparam int RESET_ACTIVE =
        (int'(swxy_pkg::WINDOW_SIZE_RESET) > WINDOW_DEPTH) ? WINDOW_DEPTH
                                                           : int'(swxy_pkg::WINDOW_SIZE_RESET);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] base,
                                               input logic [CW-1:0] off);
        logic [SUMW-1:0] s;
        s = SUMW'(base) + SUMW'(off);
        if (s >= SUMW'(WINDOW_DEPTH))
        begin
            s = s - SUMW'(WINDOW_DEPTH);
        end
        return AW'(s);
    endfunction

    function automatic logic [CW-1:0] clamp_window(
        input logic [swxy_pkg::CFG_WIDTH-1:0] size);
        logic [CW-1:0] w;
        if (size == '0)
        begin
            w = CW'(1);
        end
        else if (int'(size) > WINDOW_DEPTH)
        begin
            w = CW'(WINDOW_DEPTH);
        end
        else
        begin
            w = CW'(size);
        end
        return w;
    endfunction

    logic [1:0]                     state_reg, state_next;
    logic [swxy_pkg::CFG_WIDTH-1:0] window_size_reg;
    logic [CW-1:0]                  active_size_reg, active_size_next;
    logic [CW-1:0]                  stored_count_reg, stored_count_next;
    logic [AW-1:0]                  oldest_slot_reg, oldest_slot_next;
    logic [AW-1:0]                  scan_ptr_reg, scan_ptr_next;
    logic [CW-1:0]                  scan_left_reg, scan_left_next;
    logic                           cmp_valid_reg, cmp_valid_next;
    logic signed [SAMPLE_WIDTH-1:0] low_x_reg, high_x_reg, low_y_reg, high_y_reg;
    logic                           out_valid_reg, out_valid_next;
    logic signed [SAMPLE_WIDTH-1:0] min_x_reg, max_x_reg, min_y_reg, max_y_reg;
    logic [CW-1:0]                  count_out_reg;

    logic                           accept;
    logic                           is_full;
    logic                           out_load;
    logic                           ram_we;
    logic [AW-1:0]                  ram_waddr;
    logic [2*SAMPLE_WIDTH-1:0]      ram_rdata;
    logic                           unit_seed;
    logic                           bounds_we;
    logic signed [SAMPLE_WIDTH-1:0] pt_x, pt_y;
    logic signed [SAMPLE_WIDTH-1:0] nxt_min_x, nxt_max_x, nxt_min_y, nxt_max_y;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign is_full  = (stored_count_reg >= active_size_reg);
    assign out_load = (state_reg == ST_FINISH) && (!out_valid_reg || out_ready);

    // store write: append while filling, overwrite oldest once full
    assign ram_we    = accept && (func == swxy_pkg::FUNC_ADD);
    assign ram_waddr = is_full ? oldest_slot_reg : ring_add(oldest_slot_reg, stored_count_reg);

    swxy_ram #(
        .WIDTH (2 * SAMPLE_WIDTH),
        .DEPTH (WINDOW_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata ({x_value, y_value}),
        .raddr (scan_ptr_reg),
        .rdata (ram_rdata)
    );

    // compare unit takes the incoming point on accept, RAM data while scanning
    assign pt_x      = in_ready ? x_value : ram_rdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];
    assign pt_y      = in_ready ? y_value : ram_rdata[SAMPLE_WIDTH-1:0];
    assign unit_seed = in_ready && (is_full || (stored_count_reg == '0));
    assign bounds_we = ram_we || cmp_valid_reg;

    swxy_bound_unit #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_bound (
        .seed      (unit_seed),
        .pt_x      (pt_x),
        .pt_y      (pt_y),
        .cur_min_x (low_x_reg),
        .cur_max_x (high_x_reg),
        .cur_min_y (low_y_reg),
        .cur_max_y (high_y_reg),
        .nxt_min_x (nxt_min_x),
        .nxt_max_x (nxt_max_x),
        .nxt_min_y (nxt_min_y),
        .nxt_max_y (nxt_max_y)
    );

    always_comb
    begin
        state_next        = state_reg;
        active_size_next  = active_size_reg;
        stored_count_next = stored_count_reg;
        oldest_slot_next  = oldest_slot_reg;
        scan_ptr_next     = scan_ptr_reg;
        scan_left_next    = scan_left_reg;
        cmp_valid_next    = 1'b0;
        out_valid_next    = out_valid_reg;

        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_FINISH;
                    if (func == swxy_pkg::FUNC_CLEAR)
                    begin
                        stored_count_next = '0;
                        oldest_slot_next  = '0;
                        active_size_next  = clamp_window(window_size_reg);
                    end
                    else if (!is_full)
                    begin
                        stored_count_next = stored_count_reg + CW'(1);
                    end
                    else
                    begin
                        oldest_slot_next = ring_add(oldest_slot_reg, CW'(1));
                        scan_ptr_next    = ring_add(oldest_slot_reg, CW'(1));
                        scan_left_next   = stored_count_reg;
                        state_next       = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                // read issued here, compared in the cycle after
                if (scan_left_reg != '0)
                begin
                    cmp_valid_next = 1'b1;
                    scan_ptr_next  = ring_add(scan_ptr_reg, CW'(1));
                    scan_left_next = scan_left_reg - CW'(1);
                end
                else if (!cmp_valid_reg)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            window_size_reg  <= swxy_pkg::WINDOW_SIZE_RESET;
            active_size_reg  <= CW'(RESET_ACTIVE);
            stored_count_reg <= '0;
            oldest_slot_reg  <= '0;
            scan_ptr_reg     <= '0;
            scan_left_reg    <= '0;
            cmp_valid_reg    <= 1'b0;
            out_valid_reg    <= 1'b0;
            low_x_reg        <= '0;
            high_x_reg       <= '0;
            low_y_reg        <= '0;
            high_y_reg       <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            active_size_reg  <= active_size_next;
            stored_count_reg <= stored_count_next;
            oldest_slot_reg  <= oldest_slot_next;
            scan_ptr_reg     <= scan_ptr_next;
            scan_left_reg    <= scan_left_next;
            cmp_valid_reg    <= cmp_valid_next;
            out_valid_reg    <= out_valid_next;
            if (cfg_we)
            begin
                window_size_reg <= cfg_data;
            end
            if (bounds_we)
            begin
                low_x_reg  <= nxt_min_x;
                high_x_reg <= nxt_max_x;
                low_y_reg  <= nxt_min_y;
                high_y_reg <= nxt_max_y;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            min_x_reg     <= low_x_reg;
            max_x_reg     <= high_x_reg;
            min_y_reg     <= low_y_reg;
            max_y_reg     <= high_y_reg;
            count_out_reg <= stored_count_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign min_x       = min_x_reg;
    assign max_x       = max_x_reg;
    assign min_y       = min_y_reg;
    assign max_y       = max_y_reg;
    assign point_count = count_out_reg;

    a_count_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        stored_count_reg <= active_size_reg)
        else $error("stored count exceeds active window");

    a_full_add_scans: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (func == swxy_pkg::FUNC_ADD) && is_full |=> state_reg == ST_SCAN)
        else $error("add into full window did not start a rescan");

    a_cmp_only_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        cmp_valid_reg |-> state_reg == ST_SCAN)
        else $error("compare data outside rescan");

    a_bounds_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> (low_x_reg <= high_x_reg) && (low_y_reg <= high_y_reg))
        else $error("bounds out of order");

    a_active_legal: assert property (@(posedge clk) disable iff (!rst_n)
        (active_size_reg != '0) && (active_size_reg <= CW'(WINDOW_DEPTH)))
        else $error("active window size out of range");

endmodule

`default_nettype wire
